// ===== rtl/core/lsc_pkg.sv =====
// Shared types and constants for the lightmap style combiner.
package lsc_pkg;

  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 12;
  localparam int PART_W   = SAMPLE_W + GAIN_W;   // sample * gain
  localparam int PROD_W   = PART_W + GAIN_W;     // sample * gain * modulate
  localparam int ACC_W    = 36;
  localparam int FRAC_W   = 16;
  localparam int INT_W    = ACC_W - FRAC_W;      // integer part of a channel
  localparam int SCALED_W = INT_W + 8;           // integer part times 255
  localparam int LANES    = 4;                   // red, green, blue, alpha
  localparam int STEP_W   = 3;                   // eight quotient bits

  localparam logic [7:0]        FULL_LEVEL     = 8'd255;
  localparam logic [GAIN_W-1:0] MODULATE_RESET = 12'd256;
  localparam logic [ACC_W-1:0]  ACC_MAX        = {ACC_W{1'b1}};

  // Item class decided by the front end
  typedef enum logic [1:0] {
    OP_ADD,    // add to what the accumulators hold
    OP_FIRST,  // clear, then add
    OP_LAST,   // add, then emit
    OP_SOLE    // clear, add, emit
  } op_t;

  typedef struct packed {
    logic [PART_W-1:0] part_red;
    logic [PART_W-1:0] part_green;
    logic [PART_W-1:0] part_blue;
    op_t               op;
  } item_t;

  typedef struct packed {
    logic [INT_W-1:0] x_red;
    logic [INT_W-1:0] x_green;
    logic [INT_W-1:0] x_blue;
    logic [INT_W-1:0] peak;
  } norm_req_t;

  typedef struct packed {
    logic [7:0] q_red;
    logic [7:0] q_green;
    logic [7:0] q_blue;
    logic [7:0] q_alpha;
  } norm_res_t;

endpackage

// ===== rtl/core/lsc_front.sv =====
// Front end: accepts style samples, forms sample times gain and classifies the item.
module lsc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lsc_pkg::SAMPLE_W-1:0]      sample_red,
  input  logic [lsc_pkg::SAMPLE_W-1:0]      sample_green,
  input  logic [lsc_pkg::SAMPLE_W-1:0]      sample_blue,
  input  logic [lsc_pkg::GAIN_W-1:0]        gain_red,
  input  logic [lsc_pkg::GAIN_W-1:0]        gain_green,
  input  logic [lsc_pkg::GAIN_W-1:0]        gain_blue,
  input  logic                              first_style,
  input  logic                              last_style,
  output logic                              push_valid,
  input  logic                              push_ready,
  output lsc_pkg::item_t                    push_item
);

  logic            stage_valid;
  lsc_pkg::item_t  stage;
  lsc_pkg::op_t    op_next;

  // Classify by the two marks
  always_comb begin
    case ({first_style, last_style})
      2'b00:   op_next = lsc_pkg::OP_ADD;
      2'b10:   op_next = lsc_pkg::OP_FIRST;
      2'b01:   op_next = lsc_pkg::OP_LAST;
      default: op_next = lsc_pkg::OP_SOLE;
    endcase
  end

  assign in_ready   = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage;

  // Hold one item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.part_red   <= lsc_pkg::PART_W'(sample_red) * lsc_pkg::PART_W'(gain_red);
      stage.part_green <= lsc_pkg::PART_W'(sample_green) * lsc_pkg::PART_W'(gain_green);
      stage.part_blue  <= lsc_pkg::PART_W'(sample_blue) * lsc_pkg::PART_W'(gain_blue);
      stage.op         <= op_next;
    end
  end

endmodule

// ===== rtl/core/lsc_queue.sv =====
// Two-entry queue between the front and back ends.
module lsc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lsc_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop,
  output lsc_pkg::item_t  pop_item
);

  lsc_pkg::item_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/lsc_norm.sv =====
// Rescale unit: four restoring dividers giving floor(x * 255 / peak), one bit a cycle.
module lsc_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lsc_pkg::norm_req_t  req,
  output logic                done,
  output lsc_pkg::norm_res_t  res
);

  logic                            busy;
  logic [lsc_pkg::STEP_W-1:0]      step;
  logic [lsc_pkg::INT_W-1:0]       peak;
  logic [lsc_pkg::SCALED_W-1:0]    rem      [lsc_pkg::LANES];
  logic [7:0]                      quo      [lsc_pkg::LANES];
  logic [lsc_pkg::SCALED_W-1:0]    rem_next [lsc_pkg::LANES];
  logic                            bit_next [lsc_pkg::LANES];
  logic [lsc_pkg::SCALED_W-1:0]    divisor;
  logic [lsc_pkg::INT_W-1:0]       x_in     [lsc_pkg::LANES];

  assign x_in[0] = req.x_red;
  assign x_in[1] = req.x_green;
  assign x_in[2] = req.x_blue;
  assign x_in[3] = lsc_pkg::INT_W'(lsc_pkg::FULL_LEVEL);

  // Trial subtract of peak shifted to the current quotient bit
  always_comb begin
    divisor = lsc_pkg::SCALED_W'(peak) << step;
    for (int i = 0; i < lsc_pkg::LANES; i++) begin
      bit_next[i] = (rem[i] >= divisor);
      rem_next[i] = bit_next[i] ? (rem[i] - divisor) : rem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= lsc_pkg::STEP_W'(7);
      end else if (busy) begin
        step <= step - lsc_pkg::STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load x * 255, then take one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      peak <= req.peak;
      for (int i = 0; i < lsc_pkg::LANES; i++) begin
        rem[i] <= (lsc_pkg::SCALED_W'(x_in[i]) << 8) - lsc_pkg::SCALED_W'(x_in[i]);
        quo[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < lsc_pkg::LANES; i++) begin
        rem[i]       <= rem_next[i];
        quo[i][step] <= bit_next[i];
      end
    end
  end

  assign res.q_red   = quo[0];
  assign res.q_green = quo[1];
  assign res.q_blue  = quo[2];
  assign res.q_alpha = quo[3];

endmodule

// ===== rtl/core/lsc_back.sv =====
// Back end: applies modulate, accumulates with saturation and emits texels, rescaled when the peak is above 255.
module lsc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lsc_pkg::GAIN_W-1:0]    modulate,
  input  logic                          pop_valid,
  output logic                          pop,
  input  lsc_pkg::item_t                pop_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_PEAK,
    S_DIV,
    S_OUT
  } state_t;

  state_t                        state;
  logic [lsc_pkg::PROD_W-1:0]    prod_red;
  logic [lsc_pkg::PROD_W-1:0]    prod_green;
  logic [lsc_pkg::PROD_W-1:0]    prod_blue;
  logic                          clear;
  logic                          emit;
  logic [lsc_pkg::ACC_W-1:0]     acc_red;
  logic [lsc_pkg::ACC_W-1:0]     acc_green;
  logic [lsc_pkg::ACC_W-1:0]     acc_blue;
  logic [lsc_pkg::ACC_W-1:0]     acc_red_next;
  logic [lsc_pkg::ACC_W-1:0]     acc_green_next;
  logic [lsc_pkg::ACC_W-1:0]     acc_blue_next;
  logic [7:0]                    pend_red;
  logic [7:0]                    pend_green;
  logic [7:0]                    pend_blue;
  logic [7:0]                    pend_alpha;
  lsc_pkg::norm_req_t            req;
  lsc_pkg::norm_res_t            res;
  logic                          norm_start;
  logic                          norm_done;
  logic                          scale;

  // Saturating add onto a cleared or held accumulator
  function automatic logic [lsc_pkg::ACC_W-1:0] sat_add(
    input logic [lsc_pkg::ACC_W-1:0]  acc,
    input logic                       clr,
    input logic [lsc_pkg::PROD_W-1:0] prod
  );
    logic [lsc_pkg::ACC_W:0] sum;
    sum = (clr ? '0 : {1'b0, acc}) + (lsc_pkg::ACC_W+1)'(prod);
    return sum[lsc_pkg::ACC_W] ? lsc_pkg::ACC_MAX : sum[lsc_pkg::ACC_W-1:0];
  endfunction

  always_comb begin
    acc_red_next   = sat_add(acc_red, clear, prod_red);
    acc_green_next = sat_add(acc_green, clear, prod_green);
    acc_blue_next  = sat_add(acc_blue, clear, prod_blue);
  end

  // Integer parts and the brightest channel
  always_comb begin
    req.x_red   = acc_red[lsc_pkg::ACC_W-1:lsc_pkg::FRAC_W];
    req.x_green = acc_green[lsc_pkg::ACC_W-1:lsc_pkg::FRAC_W];
    req.x_blue  = acc_blue[lsc_pkg::ACC_W-1:lsc_pkg::FRAC_W];
    req.peak    = (req.x_red > req.x_green) ? req.x_red : req.x_green;
    if (req.x_blue > req.peak) req.peak = req.x_blue;
    scale = (req.peak > lsc_pkg::INT_W'(lsc_pkg::FULL_LEVEL));
  end

  assign pop        = (state == S_IDLE) && pop_valid;
  assign norm_start = (state == S_PEAK) && scale;

  lsc_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .req   (req),
    .done  (norm_done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc_red   <= '0;
      acc_green <= '0;
      acc_blue  <= '0;
    end else begin
      // Drop valid after a transfer unless a new texel replaces it
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop_valid) state <= S_ACC;
        end
        S_ACC: begin
          acc_red   <= acc_red_next;
          acc_green <= acc_green_next;
          acc_blue  <= acc_blue_next;
          state     <= emit ? S_PEAK : S_IDLE;
        end
        S_PEAK: begin
          // Drop the accumulators once the texel is captured
          acc_red   <= '0;
          acc_green <= '0;
          acc_blue  <= '0;
          state     <= scale ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (norm_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      prod_red   <= lsc_pkg::PROD_W'(pop_item.part_red) * lsc_pkg::PROD_W'(modulate);
      prod_green <= lsc_pkg::PROD_W'(pop_item.part_green) * lsc_pkg::PROD_W'(modulate);
      prod_blue  <= lsc_pkg::PROD_W'(pop_item.part_blue) * lsc_pkg::PROD_W'(modulate);
      clear      <= pop_item.op inside {lsc_pkg::OP_FIRST, lsc_pkg::OP_SOLE};
      emit       <= pop_item.op inside {lsc_pkg::OP_LAST, lsc_pkg::OP_SOLE};
    end
    if (state == S_PEAK && !scale) begin
      pend_red   <= req.x_red[7:0];
      pend_green <= req.x_green[7:0];
      pend_blue  <= req.x_blue[7:0];
      pend_alpha <= lsc_pkg::FULL_LEVEL;
    end
    if (state == S_DIV && norm_done) begin
      pend_red   <= res.q_red;
      pend_green <= res.q_green;
      pend_blue  <= res.q_blue;
      pend_alpha <= res.q_alpha;
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_red   <= pend_red;
      out_green <= pend_green;
      out_blue  <= pend_blue;
      out_alpha <= pend_alpha;
    end
  end

endmodule

// ===== rtl/core/lightmap_style_combine_top.sv =====
// Top level of the lightmap style combiner: modulate register, front end, queue, back end.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   sample_*, gain_*, first_style, last_style
//   out       output     out_valid / out_ready out_red, out_green, out_blue, out_alpha
//   cfg       input      cfg_we                cfg_wdata (modulate)
//
// The back end takes each style sample through S_IDLE (modulate multiply), then S_ACC
// (accumulate). A style marked last then passes S_PEAK to find the brightest channel
// and, when it is above 255, waits in S_DIV on the bit-a-cycle rescale unit (eight
// quotient bits and its done pulse), then moves to the output register in S_OUT. The
// front end and a two-entry queue keep accepting meanwhile.
// Synchronous reset clears all control state, the accumulators and sets modulate to 1.0.
// A stalled output holds the back end in its final state; the queue then fills and
// in_ready falls.
module lightmap_style_combine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsc_pkg::GAIN_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsc_pkg::SAMPLE_W-1:0]  sample_red,
  input  logic [lsc_pkg::SAMPLE_W-1:0]  sample_green,
  input  logic [lsc_pkg::SAMPLE_W-1:0]  sample_blue,
  input  logic [lsc_pkg::GAIN_W-1:0]    gain_red,
  input  logic [lsc_pkg::GAIN_W-1:0]    gain_green,
  input  logic [lsc_pkg::GAIN_W-1:0]    gain_blue,
  input  logic                          first_style,
  input  logic                          last_style,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha
);

  logic [lsc_pkg::GAIN_W-1:0] modulate;
  logic                       push_valid;
  logic                       push_ready;
  lsc_pkg::item_t             push_item;
  logic                       pop_valid;
  logic                       pop;
  lsc_pkg::item_t             pop_item;

  // Hold the global modulation gain
  always_ff @(posedge clk) begin
    if (rst) begin
      modulate <= lsc_pkg::MODULATE_RESET;
    end else if (cfg_we) begin
      modulate <= cfg_wdata;
    end
  end

  lsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue),
    .gain_red     (gain_red),
    .gain_green   (gain_green),
    .gain_blue    (gain_blue),
    .first_style  (first_style),
    .last_style   (last_style),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  lsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  lsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .modulate  (modulate),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule

// ===== test/lightmap_style_combine_top_test.sv =====
// Self-checking testbench for the lightmap style combiner: style sample stream, texel checks.
`timescale 1ns / 1ps

module lightmap_style_combine_top_test;

  localparam int MAX_STYLES    = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 32;

  typedef struct packed {
    logic [lsc_pkg::SAMPLE_W-1:0] s_red;
    logic [lsc_pkg::SAMPLE_W-1:0] s_green;
    logic [lsc_pkg::SAMPLE_W-1:0] s_blue;
    logic [lsc_pkg::GAIN_W-1:0]   g_red;
    logic [lsc_pkg::GAIN_W-1:0]   g_green;
    logic [lsc_pkg::GAIN_W-1:0]   g_blue;
    logic                         first;
    logic                         last;
  } style_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_t;

  // Predicts finished texels from accepted style samples and checks them in order
  class texel_scoreboard;
    longint unsigned modulate;
    longint unsigned acc[3];
    texel_t          texel_q[$];
    int              errors;
    string           lane_name[4] = '{"red", "green", "blue", "alpha"};

    function new();
      modulate = lsc_pkg::MODULATE_RESET;
      acc      = '{0, 0, 0};
      errors   = 0;
    endfunction

    function void set_modulate(logic [lsc_pkg::GAIN_W-1:0] value);
      modulate = value;
    endfunction

    function int pending();
      return texel_q.size();
    endfunction

    // Accumulate one style; on the last style, normalise and queue the texel
    function void note_style(style_t s);
      longint unsigned smp[3];
      longint unsigned gain[3];
      longint unsigned sum;
      longint unsigned x[3];
      longint unsigned alpha;
      longint unsigned peak;
      texel_t          want;
      smp  = '{s.s_red, s.s_green, s.s_blue};
      gain = '{s.g_red, s.g_green, s.g_blue};
      if (s.first) acc = '{0, 0, 0};
      for (int ch = 0; ch < 3; ch++) begin
        sum     = acc[ch] + smp[ch] * gain[ch] * modulate;
        acc[ch] = (sum > lsc_pkg::ACC_MAX) ? longint'(lsc_pkg::ACC_MAX) : sum;
      end
      if (!s.last) return;
      for (int ch = 0; ch < 3; ch++) x[ch] = acc[ch] >> lsc_pkg::FRAC_W;
      alpha = lsc_pkg::FULL_LEVEL;
      peak  = (x[0] > x[1]) ? x[0] : x[1];
      if (x[2] > peak) peak = x[2];
      // Scale everything down by the brightest channel
      if (peak > lsc_pkg::FULL_LEVEL) begin
        for (int ch = 0; ch < 3; ch++) x[ch] = x[ch] * lsc_pkg::FULL_LEVEL / peak;
        alpha = alpha * lsc_pkg::FULL_LEVEL / peak;
      end
      want.red   = 8'(x[0]);
      want.green = 8'(x[1]);
      want.blue  = 8'(x[2]);
      want.alpha = 8'(alpha);
      texel_q.push_back(want);
      acc = '{0, 0, 0};
    endfunction

    function void check_texel(texel_t got);
      texel_t want;
      if (texel_q.size() == 0) begin
        $display("%0t: texel %0d/%0d/%0d/%0d arrived with none expected", $time,
                 got.red, got.green, got.blue, got.alpha);
        errors++;
        return;
      end
      want = texel_q.pop_front();
      for (int lane = 0; lane < 4; lane++) begin
        if (want[31-8*lane -: 8] !== got[31-8*lane -: 8]) begin
          $display("%0t: texel %s expected %0d, got %0d", $time, lane_name[lane],
                   want[31-8*lane -: 8], got[31-8*lane -: 8]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [lsc_pkg::GAIN_W-1:0]   cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic [lsc_pkg::SAMPLE_W-1:0] sample_red;
  logic [lsc_pkg::SAMPLE_W-1:0] sample_green;
  logic [lsc_pkg::SAMPLE_W-1:0] sample_blue;
  logic [lsc_pkg::GAIN_W-1:0]   gain_red;
  logic [lsc_pkg::GAIN_W-1:0]   gain_green;
  logic [lsc_pkg::GAIN_W-1:0]   gain_blue;
  logic                         first_style;
  logic                         last_style;
  logic                         out_valid;
  logic                         out_ready;
  logic [7:0]                   out_red;
  logic [7:0]                   out_green;
  logic [7:0]                   out_blue;
  logic [7:0]                   out_alpha;

  bit              in_burst;
  bit              out_burst;
  texel_scoreboard sb;

  lightmap_style_combine_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_red   (sample_red),
    .sample_green (sample_green),
    .sample_blue  (sample_blue),
    .gain_red     (gain_red),
    .gain_green   (gain_green),
    .gain_blue    (gain_blue),
    .first_style  (first_style),
    .last_style   (last_style),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic style_t make_style(int sr, int sg, int sbl, int gr, int gg, int gb,
                                        bit first, bit last);
    style_t s;
    s.s_red   = lsc_pkg::SAMPLE_W'(sr);
    s.s_green = lsc_pkg::SAMPLE_W'(sg);
    s.s_blue  = lsc_pkg::SAMPLE_W'(sbl);
    s.g_red   = lsc_pkg::GAIN_W'(gr);
    s.g_green = lsc_pkg::GAIN_W'(gg);
    s.g_blue  = lsc_pkg::GAIN_W'(gb);
    s.first   = first;
    s.last    = last;
    return s;
  endfunction

  function automatic logic [lsc_pkg::SAMPLE_W-1:0] pick_sample(bit hot);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (hot) return lsc_pkg::SAMPLE_W'($urandom_range(240, 255));
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return lsc_pkg::SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // Spread gains so that some texels stay in range and others need rescaling
  function automatic logic [lsc_pkg::GAIN_W-1:0] pick_gain(bit hot);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (hot) return lsc_pkg::GAIN_W'($urandom_range(3800, 4095));
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 4) return lsc_pkg::GAIN_W'($urandom_range(0, 96));
    if (roll < 7) return lsc_pkg::GAIN_W'($urandom_range(0, 300));
    return lsc_pkg::GAIN_W'($urandom_range(0, 4095));
  endfunction

  // Present one style sample and hold it until the transfer
  task automatic send_style(style_t s);
    int gap;
    bit took;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_red   <= s.s_red;
    sample_green <= s.s_green;
    sample_blue  <= s.s_blue;
    gain_red     <= s.g_red;
    gain_green   <= s.g_green;
    gain_blue    <= s.g_blue;
    first_style  <= s.first;
    last_style   <= s.last;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sb.note_style(s);
  endtask

  // Drop valid, wait for every texel, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulate(logic [lsc_pkg::GAIN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_modulate(value);
  endtask

  // Random texels: mostly short, some over MAX_STYLES, some long and hot enough to saturate
  task automatic run_texels(int n_items);
    int     sent;
    int     len;
    int     kind;
    style_t s;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) len = $urandom_range(17, 20);
      else if (kind < 30) len = $urandom_range(MAX_STYLES + 1, 2 * MAX_STYLES);
      else len = $urandom_range(1, MAX_STYLES);
      for (int i = 0; i < len; i++) begin
        s.s_red   = pick_sample(kind < 15);
        s.s_green = pick_sample(kind < 15);
        s.s_blue  = pick_sample(kind < 15);
        s.g_red   = pick_gain(kind < 15);
        s.g_green = pick_gain(kind < 15);
        s.g_blue  = pick_gain(kind < 15);
        s.first   = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        s.last    = (i == len - 1);
        send_style(s);
        sent++;
      end
    end
  endtask

  // Accept texels with random stalls
  initial begin
    int     gap;
    bit     got;
    texel_t t;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_valid;
        t   = {out_red, out_green, out_blue, out_alpha};
        @(posedge clk);
      end while (!got);
      sb.check_texel(t);
    end
  end

  // Abort when no transfer happens for too long
  initial begin
    int idle;
    bit moved;
    idle = 0;
    forever begin
      @(negedge clk);
      moved = (in_valid && in_ready) || (out_valid && out_ready);
      @(posedge clk);
      idle = moved ? 0 : idle + 1;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [lsc_pkg::GAIN_W-1:0] phase_mod[6];
    int                         phase_len[6];
    sb           = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    sample_red   = '0;
    sample_green = '0;
    sample_blue  = '0;
    gain_red     = '0;
    gain_green   = '0;
    gain_blue    = '0;
    first_style  = 1'b0;
    last_style   = 1'b0;
    in_burst     = 1'b0;
    out_burst    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed texels at the reset modulate of 1.0
    send_style(make_style(0, 0, 0, 0, 0, 0, 1, 1));
    send_style(make_style(255, 255, 255, 256, 256, 256, 1, 1));
    send_style(make_style(255, 0, 0, 257, 0, 0, 1, 1));
    send_style(make_style(255, 255, 255, 4095, 4095, 4095, 1, 1));
    send_style(make_style(255, 128, 1, 4095, 1, 4095, 1, 1));
    send_style(make_style(1, 1, 1, 1, 1, 1, 1, 1));
    // one channel per style, summed over three styles
    send_style(make_style(100, 0, 0, 200, 0, 0, 1, 0));
    send_style(make_style(0, 100, 0, 0, 200, 0, 0, 0));
    send_style(make_style(0, 0, 100, 0, 0, 200, 0, 1));
    // texel without a first mark starts clean after the previous one
    send_style(make_style(50, 60, 70, 256, 256, 256, 0, 0));
    send_style(make_style(10, 20, 30, 256, 256, 256, 0, 1));
    // a first mark mid-texel discards what came before it
    send_style(make_style(255, 255, 255, 4095, 4095, 4095, 1, 0));
    send_style(make_style(20, 40, 60, 256, 256, 256, 1, 0));
    send_style(make_style(20, 40, 60, 256, 256, 256, 0, 1));
    // more styles than MAX_STYLES keep accumulating
    for (int i = 0; i <= MAX_STYLES; i++)
      send_style(make_style(200, 150, 100, 300, 300, 300, i == 0, i == MAX_STYLES));
    settle();

    // Random phases over a spread of modulate settings
    phase_mod = '{12'd0, 12'd4095, 12'd1,
                  lsc_pkg::GAIN_W'($urandom_range(2, 4094)),
                  lsc_pkg::MODULATE_RESET,
                  lsc_pkg::GAIN_W'($urandom_range(2048, 4094))};
    phase_len = '{80, 170, 170, 170, 170, 170};
    for (int p = 0; p < 6; p++) begin
      write_modulate(phase_mod[p]);
      run_texels(phase_len[p]);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
